// File: design/cbc_pkg.sv
// ----------------------------------------------------------------------------
// cbc_pkg: shared types and constants of the cartridge bank controller
// Mapper kind codes, field widths, configuration and result bundles used by
// the core and the top level, and the bank helper functions of the core.
// ----------------------------------------------------------------------------
package cbc_pkg;

  localparam int MAX_ROM_BANKS = 512;

  localparam int ADDR_W     = 15;
  localparam int DATA_W     = 8;
  localparam int ROM_BANK_W = 9;
  localparam int FIX_BANK_W = 6;
  localparam int RAM_BANK_W = 4;
  localparam int KIND_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  localparam logic [ROM_BANK_W-1:0] ROM_MASK_LIMIT = ROM_BANK_W'(MAX_ROM_BANKS - 1);

  // mapper kinds
  localparam logic [KIND_W-1:0] KIND_PLAIN = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MBC1  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MBC2  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MBC3  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MBC5  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAPPER_KIND    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_BANK_MASK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_BANK_MASK  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MULTICART_MODE = 2'd3;

  // write areas, address bits 14:12
  localparam logic [2:0] AREA_RAM_EN_LO = 3'd0;
  localparam logic [2:0] AREA_RAM_EN_HI = 3'd1;
  localparam logic [2:0] AREA_ROM_LO    = 3'd2;
  localparam logic [2:0] AREA_ROM_HI    = 3'd3;
  localparam logic [2:0] AREA_RAM_LO    = 3'd4;
  localparam logic [2:0] AREA_RAM_HI    = 3'd5;
  localparam logic [2:0] AREA_MODE_LO   = 3'd6;
  localparam logic [2:0] AREA_MODE_HI   = 3'd7;

  localparam logic [3:0] RAM_EN_CODE = 4'hA;

  typedef struct packed {
    logic [KIND_W-1:0]     mapper_kind;
    logic [ROM_BANK_W-1:0] rom_bank_mask;
    logic [RAM_BANK_W-1:0] ram_bank_mask;
    logic                  multicart_mode;
  } cfg_t;

  typedef struct packed {
    logic                  ram_enabled;
    logic [RAM_BANK_W-1:0] mapped_ram_bank;
    logic [FIX_BANK_W-1:0] fixed_rom_bank;
    logic [ROM_BANK_W-1:0] switch_rom_bank;
  } result_t;

  // bank zero adjustment after masking
  function automatic logic [ROM_BANK_W-1:0] zero_fix(input logic [ROM_BANK_W-1:0] bank,
                                                     input logic [KIND_W-1:0] kind);
    logic [ROM_BANK_W-1:0] b;
    b = bank;
    if (kind == KIND_MBC1) begin
      if (bank[4:0] == 5'd0) b = bank + ROM_BANK_W'(1);
    end else if (kind != KIND_PLAIN) begin
      if (bank == '0) b = ROM_BANK_W'(1);
    end
    return b;
  endfunction

  // 64-bank multicart remap: bits 6:5 move to 5:4, bit 4 dropped
  function automatic logic [FIX_BANK_W-1:0] multi_bank(input logic [ROM_BANK_W-1:0] rb);
    return {rb[6:5], rb[3:0]};
  endfunction

endpackage

// File: design/cbc_core.sv
// ----------------------------------------------------------------------------
// cbc_core: bank register file and write decode
// Holds the raw and mapped bank registers, decodes one processor write per
// step and presents the mapped banks as they stand after that write.
// ----------------------------------------------------------------------------
module cbc_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  cbc_pkg::cfg_t                cfg,
  input  logic [cbc_pkg::ADDR_W-1:0]   write_address,
  input  logic [cbc_pkg::DATA_W-1:0]   write_data,
  output cbc_pkg::result_t             result_nxt
);
  import cbc_pkg::*;

  logic [ROM_BANK_W-1:0] rom_bank_r,   rom_bank_nxt;
  logic [RAM_BANK_W-1:0] ram_bank_r,   ram_bank_nxt;
  logic                  ram_en_r,     ram_en_nxt;
  logic                  mode_r,       mode_nxt;
  logic [ROM_BANK_W-1:0] map_sw_r,     map_sw_nxt;
  logic [FIX_BANK_W-1:0] map_fix_r,    map_fix_nxt;
  logic [RAM_BANK_W-1:0] map_ram_r,    map_ram_nxt;

  logic [KIND_W-1:0]     kind;
  logic [ROM_BANK_W-1:0] rom_mask;
  logic [2:0]            area;
  logic                  mbc2_sel;
  logic                  multi;
  logic [FIX_BANK_W-1:0] mb;

  // kinds above MBC5 behave as plain
  assign kind     = (cfg.mapper_kind > KIND_MBC5) ? KIND_PLAIN : cfg.mapper_kind;
  assign rom_mask = cfg.rom_bank_mask & ROM_MASK_LIMIT;
  assign area     = write_address[14:12];
  assign mbc2_sel = write_address[8];
  assign multi    = cfg.multicart_mode;

  // write decode and remap
  always_comb begin
    rom_bank_nxt = rom_bank_r;
    ram_bank_nxt = ram_bank_r;
    ram_en_nxt   = ram_en_r;
    mode_nxt     = mode_r;
    map_sw_nxt   = map_sw_r;
    map_fix_nxt  = map_fix_r;
    map_ram_nxt  = map_ram_r;
    mb           = '0;

    case (area) inside
      AREA_RAM_EN_LO, AREA_RAM_EN_HI: begin
        if (!(kind == KIND_MBC2 && mbc2_sel)) begin
          ram_en_nxt  = (write_data[3:0] == RAM_EN_CODE);
          map_ram_nxt = ram_bank_r & cfg.ram_bank_mask;
        end
      end
      AREA_ROM_LO, AREA_ROM_HI: begin
        if (kind == KIND_MBC5) begin
          if (area == AREA_ROM_LO) rom_bank_nxt = {rom_bank_r[8], write_data};
          else                     rom_bank_nxt = {write_data[0], rom_bank_r[7:0]};
          map_sw_nxt = zero_fix(rom_bank_nxt & rom_mask, kind);
        end else if (kind == KIND_MBC1) begin
          if (mode_r && !multi) rom_bank_nxt = {4'd0, write_data[4:0]};
          else                  rom_bank_nxt = {2'd0, rom_bank_r[6:5], write_data[4:0]};
          mb = multi_bank(rom_bank_nxt);
          if (mode_r && multi) map_sw_nxt = zero_fix({3'd0, mb}, KIND_MBC1);
          else                 map_sw_nxt = zero_fix(rom_bank_nxt & rom_mask, kind);
        end else if (kind == KIND_MBC2) begin
          if (mbc2_sel) begin
            rom_bank_nxt = {5'd0, write_data[3:0]};
            map_sw_nxt   = zero_fix(rom_bank_nxt & rom_mask, kind);
          end
        end else if (kind == KIND_MBC3) begin
          rom_bank_nxt = {2'd0, write_data[6:0]};
          map_sw_nxt   = zero_fix(rom_bank_nxt & rom_mask, kind);
        end
      end
      AREA_RAM_LO, AREA_RAM_HI: begin
        if (kind == KIND_MBC1) begin
          if (mode_r) begin
            if (multi) begin
              rom_bank_nxt = {2'd0, write_data[1:0], rom_bank_r[4:0]};
              mb           = multi_bank(rom_bank_nxt);
              map_fix_nxt  = {mb[5:4], 4'd0};
              map_sw_nxt   = zero_fix({3'd0, mb}, KIND_MBC1);
            end else begin
              ram_bank_nxt = {2'd0, write_data[1:0]};
              map_ram_nxt  = ram_bank_nxt & cfg.ram_bank_mask;
            end
          end else begin
            rom_bank_nxt = {2'd0, write_data[1:0], rom_bank_r[4:0]};
            map_sw_nxt   = zero_fix(rom_bank_nxt & rom_mask, kind);
          end
        end else if (kind == KIND_MBC3) begin
          ram_bank_nxt = {2'd0, write_data[1:0]};
          map_ram_nxt  = ram_bank_nxt & cfg.ram_bank_mask;
        end else if (kind == KIND_MBC5) begin
          ram_bank_nxt = write_data[3:0];
          map_ram_nxt  = ram_bank_nxt & cfg.ram_bank_mask;
        end
      end
      AREA_MODE_LO, AREA_MODE_HI: begin
        if (kind == KIND_MBC1) begin
          mode_nxt = write_data[0];
          if (multi) begin
            if (mode_nxt) begin
              mb          = multi_bank(rom_bank_r);
              map_fix_nxt = {mb[5:4], 4'd0};
              map_sw_nxt  = zero_fix({3'd0, mb}, KIND_MBC1);
            end else begin
              map_fix_nxt = '0;
              map_sw_nxt  = zero_fix(rom_bank_r & rom_mask, kind);
            end
          end
        end
      end
      default: ;
    endcase
  end

  // state update on each stepped write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bank_r <= ROM_BANK_W'(1);
      ram_bank_r <= '0;
      ram_en_r   <= 1'b0;
      mode_r     <= 1'b0;
      map_sw_r   <= ROM_BANK_W'(1);
      map_fix_r  <= '0;
      map_ram_r  <= '0;
    end else if (step) begin
      rom_bank_r <= rom_bank_nxt;
      ram_bank_r <= ram_bank_nxt;
      ram_en_r   <= ram_en_nxt;
      mode_r     <= mode_nxt;
      map_sw_r   <= map_sw_nxt;
      map_fix_r  <= map_fix_nxt;
      map_ram_r  <= map_ram_nxt;
    end
  end

  assign result_nxt.switch_rom_bank = map_sw_nxt;
  assign result_nxt.fixed_rom_bank  = map_fix_nxt;
  assign result_nxt.mapped_ram_bank = map_ram_nxt;
  assign result_nxt.ram_enabled     = ram_en_nxt;

endmodule

// File: design/cartridge_bank_controller_top.sv
// ----------------------------------------------------------------------------
// cartridge_bank_controller_top: cartridge memory bank controller
// Each input transfer is one processor write into the cartridge control
// area (address 0x0000-0x7FFF and a data byte). Each write produces exactly
// one output transfer with the switchable ROM bank, the fixed-window bank,
// the mapped RAM bank and the RAM enable as they stand after that write.
// Mapper rules follow plain, MBC1 (with multicart remap), MBC2, MBC3, MBC5.
// The configuration port sets mapper kind, ROM and RAM bank masks and the
// multicart flag; write it only while no write is in flight.
// A write accepted into the input register is decoded by the core and its
// result is loaded into the output register once that register is free or
// being taken, which raises out_tvalid. Throughput is one write per cycle
// while the receiver does not stall, set by the single decode stage between
// the input and output registers.
// When the receiver stalls, the result holds in the output register and
// the input register still takes one more write; tready drops once both
// are full. Synchronous reset empties both stages, restores the bank
// registers (ROM bank 1, RAM bank 0, RAM disabled, mode 0) and the
// configuration defaults (plain, ROM mask 1, RAM mask 0, no multicart).
// ----------------------------------------------------------------------------
module cartridge_bank_controller_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [cbc_pkg::IN_TDATA_W-1:0]      in_tdata,   // write_address, write_data
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // switch_rom_bank, fixed_rom_bank, mapped_ram_bank, ram_enabled, zero pad
  output logic [cbc_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [cbc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cbc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import cbc_pkg::*;

  cfg_t                cfg_r;
  logic                in_valid_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [DATA_W-1:0]   data_r;
  logic                out_valid_r;
  result_t             res_r;
  result_t             res_nxt;
  logic                advance;
  logic                in_xfer;

  // pipeline control
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mapper_kind    <= KIND_PLAIN;
      cfg_r.rom_bank_mask  <= ROM_BANK_W'(1);
      cfg_r.ram_bank_mask  <= '0;
      cfg_r.multicart_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAPPER_KIND:    cfg_r.mapper_kind    <= cfg_data[KIND_W-1:0];
        CFG_ROM_BANK_MASK:  cfg_r.rom_bank_mask  <= cfg_data[ROM_BANK_W-1:0];
        CFG_RAM_BANK_MASK:  cfg_r.ram_bank_mask  <= cfg_data[RAM_BANK_W-1:0];
        CFG_MULTICART_MODE: cfg_r.multicart_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_xfer) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      addr_r <= in_tdata[ADDR_W-1:0];
      data_r <= in_tdata[ADDR_W+DATA_W-1:ADDR_W];
    end
  end

  // bank decode
  cbc_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .cfg           (cfg_r),
    .write_address (addr_r),
    .write_data    (data_r),
    .result_nxt    (res_nxt)
  );

  // output register stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - $bits(result_t))'(0), res_r};

endmodule
